// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/g711_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g711_pkg
// shared types and constants of the g.711 companding codec
// ----------------------------------------------------------------------------
package g711_pkg;

    typedef enum logic {
        LAW_A  = 1'b0,
        LAW_MU = 1'b1
    } t_law;

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_DECODE = 1'b1
    } t_req_type;

    // one request transaction
    typedef struct packed {
        t_req_type          req_type;
        logic signed [15:0] pcm_sample;
        logic [7:0]         code_byte;
        logic               block_last;
    } t_req;

    // one result transaction
    typedef struct packed {
        logic [7:0]         code_out;
        logic signed [15:0] pcm_out;
        logic               last_out;
    } t_res;

    localparam t_law LAW_RESET = LAW_MU;

    // a-law even-bit inversion masks
    localparam logic [7:0] A_MASK_POS = 8'hD5;
    localparam logic [7:0] A_MASK_NEG = 8'h55;
    localparam logic [7:0] CODE_MAX   = 8'h7F;

    // mu-law clip level and bias
    localparam logic [12:0] MU_CLIP     = 13'd8159;
    localparam logic [15:0] MU_BIAS     = 16'h0084;
    localparam logic [13:0] MU_BIAS_ENC = 14'(MU_BIAS >> 2);
    localparam logic [7:0]  MU_MASK_POS = 8'hFF;
    localparam logic [7:0]  MU_MASK_NEG = 8'h7F;

    localparam logic [15:0] A_DEC_SEG0 = 16'h0008;
    localparam logic [15:0] A_DEC_BIAS = 16'h0108;

    localparam int NUM_SEG = 8;

    // upper bound of each segment
    localparam logic [12:0] A_SEG_END [NUM_SEG] = '{
        13'h001F, 13'h003F, 13'h007F, 13'h00FF,
        13'h01FF, 13'h03FF, 13'h07FF, 13'h0FFF
    };
    localparam logic [13:0] U_SEG_END [NUM_SEG] = '{
        14'h003F, 14'h007F, 14'h00FF, 14'h01FF,
        14'h03FF, 14'h07FF, 14'h0FFF, 14'h1FFF
    };

endpackage

// ----- hw/rtl/g711_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g711 channel interfaces
// valid/ready request and result channels
// ----------------------------------------------------------------------------
interface g711_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] pcm_sample;
    logic [7:0]         code_byte;
    logic               block_last;

    modport source (
        output valid, req_type, pcm_sample, code_byte, block_last,
        input  ready
    );
    modport sink (
        input  valid, req_type, pcm_sample, code_byte, block_last,
        output ready
    );
endinterface

interface g711_res_if;
    logic               valid;
    logic               ready;
    logic [7:0]         code_out;
    logic signed [15:0] pcm_out;
    logic               last_out;

    modport source (
        output valid, code_out, pcm_out, last_out,
        input  ready
    );
    modport sink (
        input  valid, code_out, pcm_out, last_out,
        output ready
    );
endinterface

// ----- hw/rtl/g711_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g711_conv
// combinational a-law / mu-law encoder and decoder
// ----------------------------------------------------------------------------
module g711_conv
    import g711_pkg::*;
(
    input  t_law i_law,
    input  t_req i_req,
    output t_res o_res
);

    logic        neg;

    logic [12:0] a_top;
    logic [12:0] a_mag;
    logic [3:0]  a_seg;
    logic [12:0] a_shift;
    logic [3:0]  a_mant;
    logic [7:0]  a_mask;
    logic [7:0]  a_code;

    logic [13:0] u_top;
    logic [14:0] u_mag;
    logic [12:0] u_clip;
    logic [13:0] u_bias;
    logic [3:0]  u_seg;
    logic [3:0]  u_sh;
    logic [13:0] u_shift;
    logic [7:0]  u_mask;
    logic [7:0]  u_code;

    logic [7:0]  ad_v;
    logic [15:0] ad_t;
    logic [15:0] ad_pcm;
    logic [7:0]  ud_v;
    logic [15:0] ud_t;
    logic [15:0] ud_pcm;

    // a-law encode
    always_comb begin
        neg    = i_req.pcm_sample[15];
        a_top  = i_req.pcm_sample[15:3];
        a_mag  = neg ? ~a_top : a_top;
        a_mask = neg ? A_MASK_NEG : A_MASK_POS;
        a_seg  = 4'(NUM_SEG);
        for (int k = NUM_SEG - 1; k >= 0; k--) begin
            if (a_mag <= A_SEG_END[k]) begin
                a_seg = 4'(k);
            end
        end
        a_shift = a_mag >> a_seg[2:0];
        a_mant  = (a_seg < 4'd2) ? a_mag[4:1] : a_shift[3:0];
        if (a_seg[3]) begin
            a_code = CODE_MAX ^ a_mask;
        end else begin
            a_code = {1'b0, a_seg[2:0], a_mant} ^ a_mask;
        end
    end

    // mu-law encode
    always_comb begin
        u_top  = i_req.pcm_sample[15:2];
        u_mag  = neg ? (15'h4000 - {1'b0, u_top}) : {1'b0, u_top};
        u_clip = (u_mag > {2'b00, MU_CLIP}) ? MU_CLIP : u_mag[12:0];
        u_bias = {1'b0, u_clip} + MU_BIAS_ENC;
        u_mask = neg ? MU_MASK_NEG : MU_MASK_POS;
        u_seg  = 4'(NUM_SEG);
        for (int k = NUM_SEG - 1; k >= 0; k--) begin
            if (u_bias <= U_SEG_END[k]) begin
                u_seg = 4'(k);
            end
        end
        u_sh    = {1'b0, u_seg[2:0]} + 4'd1;
        u_shift = u_bias >> u_sh;
        if (u_seg[3]) begin
            u_code = CODE_MAX ^ u_mask;
        end else begin
            u_code = {1'b0, u_seg[2:0], u_shift[3:0]} ^ u_mask;
        end
    end

    // a-law decode
    always_comb begin
        ad_v = i_req.code_byte ^ A_MASK_NEG;
        ad_t = {8'h00, ad_v[3:0], 4'h0};
        if (ad_v[6:4] == 3'd0) begin
            ad_t = ad_t + A_DEC_SEG0;
        end else begin
            ad_t = (ad_t + A_DEC_BIAS) << (ad_v[6:4] - 3'd1);
        end
        ad_pcm = ad_v[7] ? ad_t : (16'h0000 - ad_t);
    end

    // mu-law decode
    always_comb begin
        ud_v   = ~i_req.code_byte;
        ud_t   = ({9'h000, ud_v[3:0], 3'b000} + MU_BIAS) << ud_v[6:4];
        ud_pcm = ud_v[7] ? (MU_BIAS - ud_t) : (ud_t - MU_BIAS);
    end

    always_comb begin
        o_res.code_out = '0;
        o_res.pcm_out  = '0;
        o_res.last_out = i_req.block_last;
        case (i_req.req_type)
            REQ_ENCODE: begin
                o_res.code_out = (i_law == LAW_A) ? a_code : u_code;
            end
            REQ_DECODE: begin
                o_res.pcm_out = (i_law == LAW_A) ? ad_pcm : ud_pcm;
            end
            default: begin
                o_res.code_out = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/g711_companding_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g711_companding_codec
// g.711 a-law / mu-law encoder and decoder, when not stalled one transaction per cycle
// ----------------------------------------------------------------------------
// channel   dir   handshake      payload
// i_req     in    valid/ready    req_type, pcm_sample, code_byte, block_last
// o_res     out   valid/ready    code_out, pcm_out, last_out
// i_cfg     in    write enable   i_cfg_wdata = law select (0 a-law, 1 mu-law)
//
// path: an accepted request is registered in the input stage, then converted into the result register
// throughput: one transaction per cycle while o_res.ready is high, set by the single conversion stage
// reset: synchronous active-low, law select returns to mu-law, stages empty
// stalls: result register holds while o_res.ready is low, input stage fills
//   behind it, then i_req.ready drops
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module g711_companding_codec
    import g711_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    g711_req_if.sink    i_req,
    g711_res_if.source  o_res
);

    // law select register
    t_law r_law;

    // input stage
    logic r_in_valid;
    logic n_in_valid;
    t_req r_in;
    t_req n_in;

    // result stage
    logic r_out_valid;
    logic n_out_valid;
    t_res r_out;
    t_res n_out;

    t_res w_conv;
    logic w_out_ready;
    logic w_in_ready;
    logic w_in_take;

    // result register frees when empty or being drained
    assign w_out_ready = !r_out_valid || o_res.ready;
    // input register frees when empty or moving into the result register
    assign w_in_ready  = !r_in_valid || w_out_ready;
    assign w_in_take   = i_req.valid && w_in_ready;

    assign i_req.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_law <= LAW_RESET;
        end else if (i_cfg_we) begin
            r_law <= t_law'(i_cfg_wdata);
        end
    end

    // conversion between the two registers
    g711_conv u_conv (
        .i_law (r_law),
        .i_req (r_in),
        .o_res (w_conv)
    );

    // next state of both stages
    always_comb begin
        n_in_valid  = r_in_valid;
        n_in        = r_in;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_out_ready) begin
            n_out_valid = r_in_valid;
            n_out       = w_conv;
        end
        if (w_in_ready) begin
            n_in_valid          = i_req.valid;
            n_in.req_type       = t_req_type'(i_req.req_type);
            n_in.pcm_sample     = i_req.pcm_sample;
            n_in.code_byte      = i_req.code_byte;
            n_in.block_last     = i_req.block_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.code_out = r_out.code_out;
    assign o_res.pcm_out  = r_out.pcm_out;
    assign o_res.last_out = r_out.last_out;

    // an accepted transaction always lands in the input stage
    `ASSERT_CLK(a_take_fills, i_clk, i_rst_n, w_in_take |=> r_in_valid, "request lost")
    // a full input stage behind a stalled result must block new requests
    `ASSERT_NEVER(a_no_overrun, i_clk, i_rst_n, r_in_valid && !w_out_ready && i_req.ready, "input stage overrun")
    // a result appears only when the input stage held a transaction
    `ASSERT_CLK(a_no_phantom, i_clk, i_rst_n, (!r_in_valid && w_out_ready) |=> !r_out_valid, "result without request")
    // law select moves only on a configuration write
    `ASSERT_CLK(a_law_hold, i_clk, i_rst_n, !i_cfg_we |=> $stable(r_law), "law changed without write")

endmodule

// ----- sim/g711_companding_codec_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g711_companding_codec_tb
// self-checking bench for the g.711 a-law / mu-law codec: a queue-fed driver
// offers encode and decode requests, a monitor predicts each converted sample
// or code byte and compares it with the result stream under random stalls
// ----------------------------------------------------------------------------
module g711_companding_codec_tb;
    import g711_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 50;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 10;

    // boundary samples: zero, minus one, both extremes, last unclipped mu-law
    // magnitude, a small positive value
    localparam logic [15:0] EDGE_PCM [6] = '{
        16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7F7C, 16'h0010
    };
    // boundary code bytes: all zeros, all ones, sign bit alone, the rest alone,
    // and both a-law inversion masks
    localparam logic [7:0] EDGE_CODE [6] = '{
        8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hD5
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    g711_req_if req_if ();
    g711_res_if res_if ();

    g711_companding_codec uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // requests waiting to be offered, and conversions still owed by the block
    t_req req_backlog [$];
    t_res results_due [$];
    t_req next_req;

    t_law law_now;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   reqs_queued;
    int   reqs_taken;
    int   mismatches;
    int   cycle_count;
    int   holds_asked;
    int   holds_done;
    int   hold_left;
    bit   req_taken;

    // ------------------------------------------------------------------------
    // conversion predictor
    // ------------------------------------------------------------------------

    // a-law: 13 bits kept, segment ends at 32 << k minus one
    function automatic logic [7:0] alaw_encode(logic [15:0] smp);
        logic [12:0] top13;
        int unsigned mag, seg, code, mask;
        top13 = smp[15:3];
        if (smp[15]) begin
            top13 = ~top13;
        end
        mask = smp[15] ? 'h55 : 'hD5;
        mag  = top13;
        seg  = 8;
        for (int k = 7; k >= 0; k--) begin
            if (mag <= (32 << k) - 1) seg = k;
        end
        if (seg == 8) begin
            code = 'h7F;
        end else if (seg < 2) begin
            code = (seg << 4) | ((mag >> 1) & 'hF);
        end else begin
            code = (seg << 4) | ((mag >> seg) & 'hF);
        end
        return 8'(code ^ mask);
    endfunction

    // mu-law: 14 bits kept, magnitude clipped then biased by 33,
    // segment ends at 64 << k minus one
    function automatic logic [7:0] mulaw_encode(logic [15:0] smp);
        logic [13:0] top14;
        int unsigned mag, seg, code, mask;
        top14 = smp[15:2];
        mask  = smp[15] ? 'h7F : 'hFF;
        mag   = smp[15] ? 'h4000 - top14 : top14;
        if (mag > 8159) mag = 8159;
        mag = mag + 33;
        seg = 8;
        for (int k = 7; k >= 0; k--) begin
            if (mag <= (64 << k) - 1) seg = k;
        end
        if (seg == 8) begin
            code = 'h7F;
        end else begin
            code = (seg << 4) | ((mag >> (seg + 1)) & 'hF);
        end
        return 8'(code ^ mask);
    endfunction

    function automatic logic [15:0] alaw_decode(logic [7:0] code);
        int unsigned v, t, seg;
        int val;
        v   = code ^ 'h55;
        t   = (v & 'hF) << 4;
        seg = (v >> 4) & 'h7;
        if (seg == 0) begin
            t = t + 'h8;
        end else begin
            t = t + 'h108;
            if (seg > 1) t = t << (seg - 1);
        end
        val = (v & 'h80) ? int'(t) : -int'(t);
        return val[15:0];
    endfunction

    function automatic logic [15:0] mulaw_decode(logic [7:0] code);
        int unsigned v, t;
        int val;
        v   = code ^ 'hFF;
        t   = ((v & 'hF) << 3) + 'h84;
        t   = t << ((v >> 4) & 'h7);
        val = (v & 'h80) ? 'h84 - int'(t) : int'(t) - 'h84;
        return val[15:0];
    endfunction

    // one result per request; the field that does not apply stays zero
    function automatic t_res convert_item(t_req r, t_law law);
        t_res res;
        res          = '0;
        res.last_out = r.block_last;
        if (r.req_type == REQ_ENCODE) begin
            res.code_out = (law == LAW_A) ? alaw_encode(r.pcm_sample)
                                          : mulaw_encode(r.pcm_sample);
        end else begin
            res.pcm_out = (law == LAW_A) ? alaw_decode(r.code_byte)
                                         : mulaw_decode(r.code_byte);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset start values, watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter ends a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // request driver: changes on the falling edge, holds an offered
    // transaction until the block takes it
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_req = req_backlog.pop_front();
                req_if.valid      <= 1'b1;
                req_if.req_type   <= next_req.req_type;
                req_if.pcm_sample <= next_req.pcm_sample;
                req_if.code_byte  <= next_req.code_byte;
                req_if.block_last <= next_req.block_last;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result sink: random stalls, plus long hold-offs on request so the
    // pipeline fills and back-pressures the request side
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_if.ready <= 1'b0;
        end else if (holds_done < holds_asked) begin
            holds_done = holds_done + 1;
            hold_left  = HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: sample both channels on the rising edge; the prediction for a
    // newly accepted request is queued before the result side is checked
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_req taken;
        t_res want;
        t_res got;
        req_taken = 1'b0;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            taken.req_type   = t_req_type'(req_if.req_type);
            taken.pcm_sample = req_if.pcm_sample;
            taken.code_byte  = req_if.code_byte;
            taken.block_last = req_if.block_last;
            results_due.push_back(convert_item(taken, law_now));
            reqs_taken++;
            req_taken = 1'b1;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.code_out = res_if.code_out;
            got.pcm_out  = res_if.pcm_out;
            got.last_out = res_if.last_out;
            if (results_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result code %h pcm %h last %b",
                    got.code_out, got.pcm_out, got.last_out));
            end else begin
                want = results_due.pop_front();
                if (got.code_out !== want.code_out || got.pcm_out !== want.pcm_out ||
                    got.last_out !== want.last_out) begin
                    flag_mismatch($sformatf(
                        "code %h/%h pcm %h/%h last %b/%b (expected/actual)",
                        want.code_out, got.code_out, want.pcm_out, got.pcm_out,
                        want.last_out, got.last_out));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // mostly small magnitudes so that every segment is hit, some full-range
    // values and some right at the extremes or around zero
    function automatic logic [15:0] pick_sample();
        logic [15:0] s;
        int unsigned sel, w;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            s = $urandom;
        end else if (sel < 8) begin
            w = $urandom_range(1, 15);
            s = $urandom & ((1 << w) - 1);
            if ($urandom_range(0, 1)) s = -s;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    s = 16'h7FFF - $urandom_range(0, 200);
                end
                1: begin
                    s = 16'h8000 + $urandom_range(0, 200);
                end
                2: begin
                    s = $urandom_range(0, 8);
                end
                default: begin
                    s = 16'hFFFF - $urandom_range(0, 8);
                end
            endcase
        end
        return s;
    endfunction

    task automatic queue_req(input t_req r);
        req_backlog.push_back(r);
        reqs_queued++;
    endtask

    // law register only changes with nothing in flight
    task automatic write_law(input t_law law);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= law;
        law_now = law;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (reqs_taken != reqs_queued || results_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input t_law law, input int src_pct, input int snk_pct,
                             input bit edges, input int n_rand, input bit squeeze);
        t_req r;
        write_law(law);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        if (edges) begin
            // boundary encodes then boundary decodes, the unused field random
            for (int i = 0; i < 6; i++) begin
                r.req_type   = REQ_ENCODE;
                r.pcm_sample = EDGE_PCM[i];
                r.code_byte  = $urandom_range(0, 255);
                r.block_last = i[0];
                queue_req(r);
            end
            for (int i = 0; i < 6; i++) begin
                r.req_type   = REQ_DECODE;
                r.pcm_sample = $urandom;
                r.code_byte  = EDGE_CODE[i];
                r.block_last = ~i[0];
                queue_req(r);
            end
        end
        for (int i = 0; i < n_rand; i++) begin
            r.req_type   = $urandom_range(0, 1) ? REQ_DECODE : REQ_ENCODE;
            r.pcm_sample = pick_sample();
            r.code_byte  = $urandom_range(0, 255);
            r.block_last = ($urandom_range(0, 7) == 0);
            queue_req(r);
        end
        // sender keeps offering while the sink holds off
        if (squeeze) holds_asked++;
        wait_drained();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = 1'b0;
        req_if.pcm_sample = '0;
        req_if.code_byte  = '0;
        req_if.block_last = 1'b0;
        res_if.ready      = 1'b0;
        law_now           = LAW_MU;
        src_idle_pct      = 0;
        snk_idle_pct      = 0;
        reqs_queued       = 0;
        reqs_taken        = 0;
        mismatches        = 0;
        holds_asked       = 0;
        holds_done        = 0;
        hold_left         = 0;
        req_taken         = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // busy sender, sparse sink
        run_phase(LAW_A, 7, 63, 1'b1, 0, 1'b0);
        run_phase(LAW_MU, 7, 63, 1'b1, 290, 1'b0);
        // sparse sender, busy sink
        run_phase(LAW_A, 63, 7, 1'b0, 290, 1'b0);
        // full rate, each with one long sink hold-off
        run_phase(LAW_MU, 0, 0, 1'b0, 290, 1'b1);
        run_phase(LAW_A, 0, 0, 1'b0, 280, 1'b1);

        // catch any stray result past the pipeline depth
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/g711_pkg.sv
hw/rtl/g711_ifs.sv
hw/rtl/g711_conv.sv
hw/rtl/g711_companding_codec.sv
sim/g711_companding_codec_tb.sv
